// ===== rtl/core/tql_pkg.sv =====
// ----------------------------------------------------------------------------
// tql_pkg
// Shared types and constants of the tabular q-learning agent.
// ----------------------------------------------------------------------------
`default_nettype none

package tql_pkg;

    localparam logic [16:0]        ONE_Q16     = 17'd65536;
    localparam logic [16:0]        HALF_Q16    = 17'd32768;
    localparam logic signed [23:0] Q_INIT      = 24'sd256;
    localparam logic signed [44:0] Q_MAX       = 45'sd8388607;
    localparam logic signed [44:0] Q_MIN       = -45'sd8388608;
    localparam logic [6:0]         PERCENT     = 7'd100;

    localparam logic [16:0] LR_RST    = 17'd6554;
    localparam logic [16:0] DISC_RST  = 17'd58982;
    localparam logic [16:0] DECAY_RST = 17'd65208;
    localparam logic [16:0] FLOOR_RST = 17'd9830;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_STATE  = 2'd1,
        ST_BAD_NEXT   = 2'd2,
        ST_BAD_ACTION = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_LR    = 2'd0,
        CFG_DISC  = 2'd1,
        CFG_DECAY = 2'd2,
        CFG_FLOOR = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_OLD,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_DECAY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic cap;
        logic check;
        logic scan_rd;
        logic old_rd;
        logic mul1;
        logic mul2;
        logic mul3;
        logic sum_wr;
        logic decay;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic skip;
        logic learn;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/tql_if.sv =====
// ----------------------------------------------------------------------------
// tql_in_if / tql_out_if
// Valid-ready channels for agent steps and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tql_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [7:0]         cur_state;
    logic [3:0]         taken_action;
    logic signed [10:0] reward;
    logic [7:0]         next_state;
    logic [6:0]         random_draw;
    logic [3:0]         random_action;

    modport source (
        output valid, mode, cur_state, taken_action, reward, next_state,
               random_draw, random_action,
        input  ready
    );
    modport sink (
        input  valid, mode, cur_state, taken_action, reward, next_state,
               random_draw, random_action,
        output ready
    );
endinterface

interface tql_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         chosen_action;
    logic               explored;
    logic [1:0]         status;
    logic signed [23:0] updated_value;

    modport source (
        output valid, chosen_action, explored, status, updated_value,
        input  ready
    );
    modport sink (
        input  valid, chosen_action, explored, status, updated_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/tql_ctrl.sv =====
// ----------------------------------------------------------------------------
// tql_ctrl
// Sequencer for table clear, row scan, update arithmetic and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output tql_pkg::t_cmd      o_cmd,
    input  wire tql_pkg::t_sts i_sts
);

    tql_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tql_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tql_pkg::S_CLEAR: if (i_sts.clr_done) n_state = tql_pkg::S_IDLE;
            tql_pkg::S_IDLE:  if (i_in_valid) n_state = tql_pkg::S_CHECK;
            tql_pkg::S_CHECK: n_state = i_sts.skip ? tql_pkg::S_DONE : tql_pkg::S_SCAN;
            tql_pkg::S_SCAN:  if (i_sts.scan_last) n_state = tql_pkg::S_DRAIN;
            tql_pkg::S_DRAIN: n_state = i_sts.learn ? tql_pkg::S_OLD : tql_pkg::S_DONE;
            tql_pkg::S_OLD:   n_state = tql_pkg::S_MUL1;
            tql_pkg::S_MUL1:  n_state = tql_pkg::S_MUL2;
            tql_pkg::S_MUL2:  n_state = tql_pkg::S_MUL3;
            tql_pkg::S_MUL3:  n_state = tql_pkg::S_SUM;
            tql_pkg::S_SUM:   n_state = tql_pkg::S_DECAY;
            tql_pkg::S_DECAY: n_state = tql_pkg::S_DONE;
            tql_pkg::S_DONE:  if (i_sts.out_free) n_state = tql_pkg::S_IDLE;
            default:          n_state = tql_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tql_pkg::S_CLEAR: o_cmd.clr_en = 1'b1;
            tql_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            tql_pkg::S_CHECK: o_cmd.check   = 1'b1;
            tql_pkg::S_SCAN:  o_cmd.scan_rd = 1'b1;
            tql_pkg::S_OLD:   o_cmd.old_rd  = 1'b1;
            tql_pkg::S_MUL1:  o_cmd.mul1    = 1'b1;
            tql_pkg::S_MUL2:  o_cmd.mul2    = 1'b1;
            tql_pkg::S_MUL3:  o_cmd.mul3    = 1'b1;
            tql_pkg::S_SUM:   o_cmd.sum_wr  = 1'b1;
            tql_pkg::S_DECAY: o_cmd.decay   = 1'b1;
            tql_pkg::S_DONE:  o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tql_dp.sv =====
// ----------------------------------------------------------------------------
// tql_dp
// Q table memory, configuration registers, row max search, update arithmetic
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_dp #(
    parameter int NUM_STATES  = 64,
    parameter int NUM_ACTIONS = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [16:0]   i_cfg_data,
    input  wire tql_pkg::t_cmd i_cmd,
    output tql_pkg::t_sts      o_sts,
    tql_in_if.sink             i_in,
    tql_out_if.source          o_out
);

    localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int AW    = $clog2(NUM_ACTIONS);
    localparam int DEPTH = 2 ** (SW + AW);

    // configuration
    logic [16:0] r_lr, r_disc, r_decay, r_floor, r_rate;
    logic [16:0] w_cfg_val;

    assign w_cfg_val = (i_cfg_data > tql_pkg::ONE_Q16) ? tql_pkg::ONE_Q16 : i_cfg_data;

    // captured step
    logic               r_mode;
    logic [7:0]         r_cs, r_ns;
    logic [3:0]         r_act, r_ract;
    logic signed [10:0] r_reward;
    logic [6:0]         r_draw;

    // table
    logic signed [23:0] r_mem [DEPTH];
    logic signed [23:0] r_rdata;
    logic [SW+AW-1:0]   r_clr;
    logic [AW-1:0]      r_cnt, r_rd_idx;
    logic               r_rd_vld;
    logic signed [23:0] r_best;
    logic [AW-1:0]      r_best_idx;

    // arithmetic
    logic signed [23:0] r_old;
    logic signed [40:0] r_p1;
    logic signed [41:0] r_p2;
    logic signed [43:0] r_p3;
    logic signed [26:0] r_target;
    logic [33:0]        r_p4;

    // result
    logic               r_out_vld;
    logic [3:0]         r_o_act;
    logic               r_o_exp;
    logic [1:0]         r_o_status;
    logic signed [23:0] r_o_upd;
    logic [3:0]         r_res_act;
    logic               r_res_exp;
    logic [1:0]         r_res_status;
    logic signed [23:0] r_res_upd;

    logic               w_cs_bad, w_ns_bad, w_act_bad, w_explore;
    tql_pkg::t_status   w_status;
    logic [SW-1:0]      w_row;
    logic [SW+AW-1:0]   w_rd_addr, w_wr_addr;
    logic signed [26:0] w_target;
    logic signed [44:0] w_sum, w_rnd;
    logic signed [23:0] w_nv;
    logic [16:0]        w_oml;
    logic [17:0]        w_decayed;

    function automatic logic [3:0] f_mod_act(input logic [3:0] v);
        logic [4:0] t;
        t = {1'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (t >= 5'(NUM_ACTIONS)) t = t - 5'(NUM_ACTIONS);
        end
        return t[3:0];
    endfunction

    assign w_cs_bad  = {1'b0, r_cs} >= 9'(NUM_STATES);
    assign w_ns_bad  = {1'b0, r_ns} >= 9'(NUM_STATES);
    assign w_act_bad = {1'b0, r_act} >= 5'(NUM_ACTIONS);
    assign w_explore = {r_draw, 16'd0} < (24'(r_rate) * 24'(tql_pkg::PERCENT));

    always_comb begin
        if (w_cs_bad) begin
            w_status = tql_pkg::ST_BAD_STATE;
        end else if (r_mode && w_ns_bad) begin
            w_status = tql_pkg::ST_BAD_NEXT;
        end else if (r_mode && w_act_bad) begin
            w_status = tql_pkg::ST_BAD_ACTION;
        end else begin
            w_status = tql_pkg::ST_OK;
        end
    end

    assign w_row     = r_mode ? r_ns[SW-1:0] : r_cs[SW-1:0];
    assign w_wr_addr = {r_cs[SW-1:0], r_act[AW-1:0]};
    assign w_rd_addr = i_cmd.old_rd ? w_wr_addr : {w_row, r_cnt};

    assign w_target  = 27'(r_reward) * 27'sd256
                     + 27'((45'(r_p1) + 45'(tql_pkg::HALF_Q16)) >>> 16);
    assign w_oml     = tql_pkg::ONE_Q16 - r_lr;
    assign w_sum     = 45'(r_p2) + 45'(r_p3);
    assign w_rnd     = (w_sum + $signed(45'(tql_pkg::HALF_Q16))) >>> 16;
    assign w_nv      = (w_rnd > tql_pkg::Q_MAX) ? 24'(tql_pkg::Q_MAX) :
                       (w_rnd < tql_pkg::Q_MIN) ? 24'(tql_pkg::Q_MIN) : w_rnd[23:0];
    assign w_decayed = 18'((r_p4 + 34'(tql_pkg::HALF_Q16)) >> 16);

    // configuration and exploration rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= tql_pkg::LR_RST;
            r_disc  <= tql_pkg::DISC_RST;
            r_decay <= tql_pkg::DECAY_RST;
            r_floor <= tql_pkg::FLOOR_RST;
            r_rate  <= tql_pkg::ONE_Q16;
        end else begin
            if (i_cfg_we) begin
                case (tql_pkg::t_cfg_idx'(i_cfg_idx))
                    tql_pkg::CFG_LR:    r_lr    <= w_cfg_val;
                    tql_pkg::CFG_DISC:  r_disc  <= w_cfg_val;
                    tql_pkg::CFG_DECAY: r_decay <= w_cfg_val;
                    tql_pkg::CFG_FLOOR: r_floor <= w_cfg_val;
                    default: ;
                endcase
            end
            if (i_cmd.decay && (r_rate > r_floor)) begin
                r_rate <= w_decayed[16:0];
            end
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_mem[r_clr] <= tql_pkg::Q_INIT;
        end else if (i_cmd.sum_wr) begin
            r_mem[w_wr_addr] <= w_nv;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.clr_en) r_clr <= r_clr + 1'b1;
            if (i_cmd.cap) begin
                r_cnt <= '0;
            end else if (i_cmd.scan_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt;
        if (i_cmd.cap) begin
            r_mode   <= i_in.mode;
            r_cs     <= i_in.cur_state;
            r_ns     <= i_in.next_state;
            r_act    <= i_in.taken_action;
            r_reward <= i_in.reward;
            r_draw   <= i_in.random_draw;
            r_ract   <= i_in.random_action;
        end
        if (i_cmd.check) begin
            r_res_status <= w_status;
            r_res_upd    <= '0;
            r_res_exp    <= !r_mode && (w_cs_bad || w_explore);
            r_res_act    <= (!r_mode && (w_cs_bad || w_explore)) ? f_mod_act(r_ract) : 4'd0;
        end
        if (r_rd_vld) begin
            if ((r_rd_idx == '0) || (r_rdata > r_best)) begin
                r_best     <= r_rdata;
                r_best_idx <= r_rd_idx;
            end
        end
        if (i_cmd.old_rd && !r_mode) begin
            r_res_act <= 4'(r_best_idx);
        end
        if (i_cmd.mul1) begin
            r_old <= r_rdata;
            r_p1  <= $signed({1'b0, r_disc}) * r_best;
        end
        if (i_cmd.mul2) begin
            r_target <= w_target;
            r_p2     <= $signed({1'b0, w_oml}) * r_old;
        end
        if (i_cmd.mul3) begin
            r_p3 <= $signed({1'b0, r_lr}) * r_target;
        end
        if (i_cmd.sum_wr) begin
            r_res_upd <= w_nv;
            r_p4      <= r_rate * r_decay;
        end
        if (i_cmd.out_load) begin
            r_o_act    <= (!r_mode && !r_res_exp) ? 4'(r_best_idx) : r_res_act;
            r_o_exp    <= r_res_exp;
            r_o_status <= r_res_status;
            r_o_upd    <= r_res_upd;
        end
    end

    assign o_sts.clr_done  = i_cmd.clr_en && (r_clr == DEPTH[SW+AW-1:0] - 1'b1);
    assign o_sts.skip      = (w_status != tql_pkg::ST_OK) || (!r_mode && w_explore);
    assign o_sts.learn     = r_mode;
    assign o_sts.scan_last = r_cnt == AW'(NUM_ACTIONS - 1);
    assign o_sts.out_free  = !r_out_vld || o_out.ready;

    assign i_in.ready          = i_cmd.cap;
    assign o_out.valid         = r_out_vld;
    assign o_out.chosen_action = r_o_act;
    assign o_out.explored      = r_o_exp;
    assign o_out.status        = r_o_status;
    assign o_out.updated_value = r_o_upd;

endmodule

`default_nettype wire

// ===== rtl/core/tabular_q_learning_agent.sv =====
// ----------------------------------------------------------------------------
// tabular_q_learning_agent
// Tabular q-learning agent with epsilon-greedy action choice.
// ----------------------------------------------------------------------------
// One step is in flight at a time. After reset the table is cleared to 1.0,
// one entry per cycle over 2**(clog2(NUM_STATES)+clog2(NUM_ACTIONS)) entries,
// and no step is taken until that pass ends. A choose step that explores, and
// any step with an out-of-range operand, goes from the check straight to the
// result; an exploiting choose step first scans its row of the table through
// the single read port (one entry of the row per cycle), and a learn step also
// runs the registered multiplies and the sum that write the new table entry.
// Configuration writes are taken at any time, clamped to 1.0.
`default_nettype none

module tabular_q_learning_agent #(
    parameter int NUM_STATES  = 64,
    parameter int NUM_ACTIONS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_data,
    tql_in_if.sink           i_in,
    tql_out_if.source        o_out
);

    tql_pkg::t_cmd w_cmd;
    tql_pkg::t_sts w_sts;
    logic          w_ready;

    tql_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    tql_dp #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in       (i_in),
        .o_out      (o_out)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_ready) |=> !w_ready)
        else $error("step taken while busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result overwritten");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_en |-> !w_ready)
        else $error("step taken during table clear");

endmodule

`default_nettype wire
